// File: rtl/tam_pkg.sv
// Shared types, constants and helpers for the tile average mosaic block.
package tam_pkg;

	localparam int MAX_TILES     = 64;
	localparam int MAX_IMAGE_DIM = 4096;
	localparam int TILE_W        = $clog2(MAX_TILES);        // tile index bits
	localparam int DIM_W         = $clog2(MAX_IMAGE_DIM) + 1; // register width, holds 4096
	localparam int POS_W         = $clog2(MAX_IMAGE_DIM);    // raster counters
	localparam int TC_W          = TILE_W + 1;               // tile count register
	localparam int COVER_W       = TC_W + DIM_W;             // tile_count * tile dimension
	localparam int AREA_W        = 2 * POS_W + 1;            // tile area, holds 4096 * 4096
	localparam int SUM_W         = 32;
	localparam int CH_W          = 8;
	localparam int FIFO_DEPTH    = 4;
	localparam int CFG_IDX_W     = 3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 3'd0,
		CFG_IMAGE_HEIGHT = 3'd1,
		CFG_TILE_COUNT   = 3'd2,
		CFG_TILE_WIDTH   = 3'd3,
		CFG_TILE_HEIGHT  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [TILE_W-1:0] tile_column;
		logic [TILE_W-1:0] tile_row;
		logic [CH_W-1:0]   mean_red;
		logic [CH_W-1:0]   mean_green;
		logic [CH_W-1:0]   mean_blue;
		logic              last_tile;
	} tile_t;

	// Configuration after saturation into the legal ranges
	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [TC_W-1:0]  tile_count;
		logic [DIM_W-1:0] tile_width;
		logic [DIM_W-1:0] tile_height;
	} cfg_t;

	// Classified pixel passed from front to back
	typedef struct packed {
		logic [TILE_W-1:0] col;
		logic [TILE_W-1:0] row;
		logic              first;
		logic              done;
		logic              last;
		pixel_t            pix;
	} entry_t;

	typedef struct packed {
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
	} sum3_t;

	// Finished tile handed to the divider
	typedef struct packed {
		sum3_t             sums;
		logic [TILE_W-1:0] col;
		logic [TILE_W-1:0] row;
		logic              last;
	} div_req_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_IMAGE_DIM))
			r = DIM_W'(MAX_IMAGE_DIM);
		return r;
	endfunction

	function automatic logic [TC_W-1:0] clamp_tiles(input logic [TC_W-1:0] v);
		logic [TC_W-1:0] r;
		r = v;
		if (v == '0)
			r = TC_W'(1);
		else if (v > TC_W'(MAX_TILES))
			r = TC_W'(MAX_TILES);
		return r;
	endfunction

endpackage

// File: rtl/tam_front.sv
// Front end: raster and tile position tracking, pixel classification.
module tam_front import tam_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   pixel_valid,
	output logic   pixel_stall,
	input  pixel_t pixel,
	input  logic   fifo_full,
	output logic   push,
	output entry_t push_entry
);

	logic [POS_W-1:0]  cp_q, rp_q, cit_q, rit_q;
	logic [TILE_W-1:0] ctc_q, ctr_q;

	logic               accept, covered;
	logic [COVER_W-1:0] cover_w, cover_h;
	logic               col_end, row_end, tw_end, th_end, ctc_more, ctr_more;

	assign pixel_stall = fifo_full;
	assign accept      = pixel_valid && !fifo_full;

	// covered area and tile edge tests
	always_comb begin
		cover_w  = COVER_W'(cfg.tile_count) * COVER_W'(cfg.tile_width);
		cover_h  = COVER_W'(cfg.tile_count) * COVER_W'(cfg.tile_height);
		covered  = (COVER_W'(cp_q) < cover_w) && (COVER_W'(rp_q) < cover_h) &&
		           (TC_W'(ctc_q) < cfg.tile_count) && (TC_W'(ctr_q) < cfg.tile_count);
		col_end  = (DIM_W'(cp_q) + DIM_W'(1)) >= cfg.image_width;
		row_end  = (DIM_W'(rp_q) + DIM_W'(1)) >= cfg.image_height;
		tw_end   = (DIM_W'(cit_q) + DIM_W'(1)) >= cfg.tile_width;
		th_end   = (DIM_W'(rit_q) + DIM_W'(1)) >= cfg.tile_height;
		ctc_more = (TC_W'(ctc_q) + TC_W'(1)) < cfg.tile_count;
		ctr_more = (TC_W'(ctr_q) + TC_W'(1)) < cfg.tile_count;
	end

	assign push = accept && covered;

	always_comb begin
		push_entry.col   = ctc_q;
		push_entry.row   = ctr_q;
		push_entry.first = (cit_q == '0) && (rit_q == '0);
		push_entry.done  = tw_end && th_end;
		push_entry.last  = ((TC_W'(ctc_q) + TC_W'(1)) == cfg.tile_count) &&
		                   ((TC_W'(ctr_q) + TC_W'(1)) == cfg.tile_count);
		push_entry.pix   = pixel;
	end

	// raster and tile counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q  <= '0;
			rp_q  <= '0;
			cit_q <= '0;
			rit_q <= '0;
			ctc_q <= '0;
			ctr_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				cp_q  <= '0;
				cit_q <= '0;
				ctc_q <= '0;
				if (row_end) begin
					rp_q  <= '0;
					rit_q <= '0;
					ctr_q <= '0;
				end else begin
					rp_q <= rp_q + POS_W'(1);
					if (th_end) begin
						rit_q <= '0;
						if (ctr_more)
							ctr_q <= ctr_q + TILE_W'(1);
					end else begin
						rit_q <= rit_q + POS_W'(1);
					end
				end
			end else begin
				cp_q <= cp_q + POS_W'(1);
				if (tw_end) begin
					cit_q <= '0;
					if (ctc_more)
						ctc_q <= ctc_q + TILE_W'(1);
				end else begin
					cit_q <= cit_q + POS_W'(1);
				end
			end
		end
	end

endmodule

// File: rtl/tam_fifo.sv
// Short queue of classified pixels between front and back.
module tam_fifo import tam_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   empty,
	output logic   full
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	entry_t           ent_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head  = ent_q[rd_ptr_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(FIFO_DEPTH));

	// storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");

endmodule

// File: rtl/tam_accum.sv
// Back end: per-column colour sums in a memory, read-modify-write with forwarding.
module tam_accum import tam_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fifo_empty,
	input  entry_t   head,
	output logic     pop,
	input  logic     div_ready,
	output logic     load,
	output div_req_t req
);

	sum3_t          mem_q [MAX_TILES];
	logic [MAX_TILES-1:0] vld_q;

	logic   v_s2, fwd_s2, hit_s2;
	entry_t ent_s2;
	sum3_t  rdata_s2;
	sum3_t  wsum_q;

	logic   adv_s2;
	sum3_t  base, new_sum;

	assign adv_s2 = v_s2 && (!ent_s2.done || div_ready);
	assign pop    = !fifo_empty && (!v_s2 || adv_s2);
	assign load   = adv_s2 && ent_s2.done;

	// pick the freshest sum and add the pixel
	always_comb begin
		if (fwd_s2)
			base = wsum_q;
		else if (hit_s2)
			base = rdata_s2;
		else
			base = '0;
		if (ent_s2.first) begin
			new_sum.red   = SUM_W'(ent_s2.pix.red);
			new_sum.green = SUM_W'(ent_s2.pix.green);
			new_sum.blue  = SUM_W'(ent_s2.pix.blue);
		end else begin
			new_sum.red   = base.red   + SUM_W'(ent_s2.pix.red);
			new_sum.green = base.green + SUM_W'(ent_s2.pix.green);
			new_sum.blue  = base.blue  + SUM_W'(ent_s2.pix.blue);
		end
	end

	always_comb begin
		req.sums = new_sum;
		req.col  = ent_s2.col;
		req.row  = ent_s2.row;
		req.last = ent_s2.last;
	end

	// sum memory: registered read, write on retire
	always_ff @(posedge clk) begin
		if (adv_s2)
			mem_q[ent_s2.col] <= new_sum;
		if (pop)
			rdata_s2 <= mem_q[head.col];
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s2 <= head;
			hit_s2 <= vld_q[head.col];
		end
		if (adv_s2)
			wsum_q <= new_sum;
	end

	// stage control and written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			fwd_s2 <= 1'b0;
			vld_q  <= '0;
		end else begin
			if (adv_s2)
				vld_q[ent_s2.col] <= 1'b1;
			if (pop) begin
				v_s2   <= 1'b1;
				fwd_s2 <= adv_s2 && (ent_s2.col == head.col);
			end else if (adv_s2) begin
				v_s2   <= 1'b0;
				fwd_s2 <= 1'b0;
			end
		end
	end

	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s2 |-> v_s2) else $error("forward flag without a stage entry");

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> div_ready) else $error("tile handed to a busy divider");

endmodule

// File: rtl/tam_divider.sv
// Mean unit: three restoring dividers sharing the tile area, one bit per cycle, output register.
module tam_divider import tam_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     load,
	input  div_req_t req,
	output logic     ready,
	output logic     tile_valid,
	input  logic     tile_stall,
	output tile_t    tile
);

	localparam int CNT_W = $clog2(SUM_W);
	localparam int NCH   = 3;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [AREA_W-1:0] div_q;
	logic [SUM_W-1:0]  quo_q [NCH];
	logic [AREA_W-1:0] rem_q [NCH];
	logic [TILE_W-1:0] col_q, row_q;
	logic              last_q;

	logic [SUM_W-1:0]  quo_nx [NCH];
	logic [AREA_W-1:0] rem_nx [NCH];
	logic [SUM_W-1:0]  dvd_ld [NCH];

	assign ready      = (state_q == ST_IDLE);
	assign tile_valid = (state_q == ST_DONE);

	assign dvd_ld[0] = req.sums.red;
	assign dvd_ld[1] = req.sums.green;
	assign dvd_ld[2] = req.sums.blue;

	// one quotient bit per channel
	always_comb begin
		logic [AREA_W:0] sh;
		logic            ge;
		for (int i = 0; i < NCH; i++) begin
			sh        = {rem_q[i], quo_q[i][SUM_W-1]};
			ge        = sh >= {1'b0, div_q};
			rem_nx[i] = ge ? AREA_W'(sh - {1'b0, div_q}) : AREA_W'(sh);
			quo_nx[i] = {quo_q[i][SUM_W-2:0], ge};
		end
	end

	always_comb begin
		tile.tile_column = col_q;
		tile.tile_row    = row_q;
		tile.mean_red    = quo_q[0][CH_W-1:0];
		tile.mean_green  = quo_q[1][CH_W-1:0];
		tile.mean_blue   = quo_q[2][CH_W-1:0];
		tile.last_tile   = last_q;
	end

	// datapath
	always_ff @(posedge clk) begin
		if (load) begin
			div_q  <= AREA_W'(cfg.tile_width) * AREA_W'(cfg.tile_height);
			col_q  <= req.col;
			row_q  <= req.row;
			last_q <= req.last;
			for (int i = 0; i < NCH; i++) begin
				quo_q[i] <= dvd_ld[i];
				rem_q[i] <= '0;
			end
		end else if (state_q == ST_RUN) begin
			for (int i = 0; i < NCH; i++) begin
				quo_q[i] <= quo_nx[i];
				rem_q[i] <= rem_nx[i];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (load) begin
						state_q <= ST_RUN;
						cnt_q   <= CNT_W'(SUM_W - 1);
					end
				end
				ST_RUN: begin
					if (cnt_q == '0)
						state_q <= ST_DONE;
					else
						cnt_q <= cnt_q - CNT_W'(1);
				end
				ST_DONE: begin
					if (!tile_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (state_q == ST_RUN)) else $error("load did not start a division");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && tile_stall) |=> (state_q == ST_DONE))
		else $error("result dropped while stalled");

endmodule

// File: rtl/tile_average_mosaic_unit.sv
// Tile average mosaic: per-tile mean colour of a raster RGB stream.
//
// Pixels enter on the pixel channel (pixel_valid / pixel_stall) in raster
// order. Each pixel inside the tile grid is classified by the front end and
// queued; the back end adds it to the colour sums of its tile column. When a
// tile's last pixel arrives, the sums are divided by the tile area and one
// result leaves on the tile channel (tile_valid / tile_stall): tile position,
// mean colour and a flag on the frame's final tile.
// Throughput: one pixel per cycle while no tile completes. Each finished tile
// occupies the shared divider through its quotient bits and the hand-over, so
// tiles finishing faster than the divider frees up fill the four-entry queue and
// stall the pixel input. A finished tile passes queue, accumulator and divider.
// A stalled result holds in the output register; the divider then waits and
// the queue fills behind it before the input stalls.
// Reset clears positions, sums (per-entry written flags) and the queue; the
// registers return to 4096 x 4096 image, one 4096 x 4096 tile.
// Configuration is written through cfg_we / cfg_index / cfg_data while no
// pixel is in flight; out-of-range values are saturated into range (tile count: low 7 bits first).
module tile_average_mosaic_unit import tam_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  pixel_t               pixel,
	output logic                 tile_valid,
	input  logic                 tile_stall,
	output tile_t                tile
);

	logic [DIM_W-1:0] iw_q, ih_q, tw_q, th_q;
	logic [TC_W-1:0]  tc_q;
	cfg_t             cfg;

	logic     push, pop, fifo_empty, fifo_full, load, div_ready;
	entry_t   push_entry, head;
	div_req_t req;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q <= DIM_W'(MAX_IMAGE_DIM);
			ih_q <= DIM_W'(MAX_IMAGE_DIM);
			tc_q <= TC_W'(1);
			tw_q <= DIM_W'(MAX_IMAGE_DIM);
			th_q <= DIM_W'(MAX_IMAGE_DIM);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  iw_q <= cfg_data;
				CFG_IMAGE_HEIGHT: ih_q <= cfg_data;
				CFG_TILE_COUNT:   tc_q <= cfg_data[TC_W-1:0];
				CFG_TILE_WIDTH:   tw_q <= cfg_data;
				CFG_TILE_HEIGHT:  th_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturated view used by the datapath
	always_comb begin
		cfg.image_width  = clamp_dim(iw_q);
		cfg.image_height = clamp_dim(ih_q);
		cfg.tile_count   = clamp_tiles(tc_q);
		cfg.tile_width   = clamp_dim(tw_q);
		cfg.tile_height  = clamp_dim(th_q);
	end

	tam_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.fifo_full   (fifo_full),
		.push        (push),
		.push_entry  (push_entry)
	);

	tam_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (fifo_empty),
		.full       (fifo_full)
	);

	tam_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.head       (head),
		.pop        (pop),
		.div_ready  (div_ready),
		.load       (load),
		.req        (req)
	);

	tam_divider u_divider (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.load       (load),
		.req        (req),
		.ready      (div_ready),
		.tile_valid (tile_valid),
		.tile_stall (tile_stall),
		.tile       (tile)
	);

endmodule

// File: verif/tile_average_mosaic_unit_tb.sv
// Testbench for the tile average mosaic unit: random pixel frames against a tile mean predictor.
`timescale 1ns / 100ps

import tam_pkg::*;

// Predicts finished tiles from accepted pixels and checks the results that leave the block
class tile_mean_tracker;
	int unsigned width_reg, height_reg, count_reg, tile_w_reg, tile_h_reg;
	int unsigned red_sum [MAX_TILES];
	int unsigned green_sum [MAX_TILES];
	int unsigned blue_sum [MAX_TILES];
	int unsigned col_pos, row_pos, col_in, row_in, tile_col, tile_row;
	tile_t due_tiles [$];
	int errors;

	function new();
		width_reg = MAX_IMAGE_DIM;
		height_reg = MAX_IMAGE_DIM;
		count_reg = 1;
		tile_w_reg = MAX_IMAGE_DIM;
		tile_h_reg = MAX_IMAGE_DIM;
		foreach (red_sum[i]) begin
			red_sum[i] = 0;
			green_sum[i] = 0;
			blue_sum[i] = 0;
		end
		col_pos = 0;
		row_pos = 0;
		col_in = 0;
		row_in = 0;
		tile_col = 0;
		tile_row = 0;
		errors = 0;
	endfunction

	static function int unsigned saturate(int unsigned v, int unsigned hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function void set_register(cfg_idx_t idx, int unsigned value);
		int unsigned v;
		v = value & 32'h1FFF;
		case (idx)
			CFG_IMAGE_WIDTH:  width_reg = v;
			CFG_IMAGE_HEIGHT: height_reg = v;
			CFG_TILE_COUNT:   count_reg = v & 32'h7F;
			CFG_TILE_WIDTH:   tile_w_reg = v;
			CFG_TILE_HEIGHT:  tile_h_reg = v;
			default: ;
		endcase
	endfunction

	// One accepted pixel: accumulate, maybe finish a tile, then step the raster position
	function void add_pixel(pixel_t px);
		int unsigned iw, ih, tc, tw, th, k, area;
		tile_t done_tile;
		iw = saturate(width_reg, MAX_IMAGE_DIM);
		ih = saturate(height_reg, MAX_IMAGE_DIM);
		tc = saturate(count_reg, MAX_TILES);
		tw = saturate(tile_w_reg, MAX_IMAGE_DIM);
		th = saturate(tile_h_reg, MAX_IMAGE_DIM);

		if (col_pos < tc * tw && row_pos < tc * th && tile_col < tc && tile_row < tc) begin
			k = tile_col;
			// first pixel of a tile restarts its column's sums
			if (col_in == 0 && row_in == 0) begin
				red_sum[k] = px.red;
				green_sum[k] = px.green;
				blue_sum[k] = px.blue;
			end else begin
				red_sum[k] += px.red;
				green_sum[k] += px.green;
				blue_sum[k] += px.blue;
			end
			if (col_in + 1 >= tw && row_in + 1 >= th) begin
				area = tw * th;
				done_tile.tile_column = TILE_W'(tile_col);
				done_tile.tile_row = TILE_W'(tile_row);
				done_tile.mean_red = CH_W'(red_sum[k] / area);
				done_tile.mean_green = CH_W'(green_sum[k] / area);
				done_tile.mean_blue = CH_W'(blue_sum[k] / area);
				done_tile.last_tile = (tile_col + 1 == tc && tile_row + 1 == tc);
				due_tiles.push_back(done_tile);
			end
		end

		// raster and tile counters
		if (col_pos + 1 >= iw) begin
			col_pos = 0;
			col_in = 0;
			tile_col = 0;
			if (row_pos + 1 >= ih) begin
				row_pos = 0;
				row_in = 0;
				tile_row = 0;
			end else begin
				row_pos++;
				if (row_in + 1 >= th) begin
					row_in = 0;
					if (tile_row + 1 < tc)
						tile_row++;
				end else begin
					row_in++;
				end
			end
		end else begin
			col_pos++;
			if (col_in + 1 >= tw) begin
				col_in = 0;
				if (tile_col + 1 < tc)
					tile_col++;
			end else begin
				col_in++;
			end
		end
	endfunction

	function void compare_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			errors++;
		end
	endfunction

	function void match_tile(tile_t got);
		tile_t want;
		if (due_tiles.size() == 0) begin
			$display("%0t: unexpected tile, expected none, got %p", $time, got);
			errors++;
			return;
		end
		want = due_tiles.pop_front();
		compare_field("tile_column", want.tile_column, got.tile_column);
		compare_field("tile_row", want.tile_row, got.tile_row);
		compare_field("mean_red", want.mean_red, got.mean_red);
		compare_field("mean_green", want.mean_green, got.mean_green);
		compare_field("mean_blue", want.mean_blue, got.mean_blue);
		compare_field("last_tile", want.last_tile, got.last_tile);
	endfunction
endclass

module tile_average_mosaic_unit_tb;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int DRAIN_CYCLES = 48;  // divider latency plus queue and margin
	localparam int RANDOM_PIXELS = 700;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	logic                 pixel_valid;
	logic                 pixel_stall;
	pixel_t               pixel;
	logic                 tile_valid;
	logic                 tile_stall;
	tile_t                tile;

	tile_mean_tracker tracker;
	bit quiet;
	int cycle_count = 0;
	int unsigned pattern_step = 0;

	tile_average_mosaic_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.tile_valid(tile_valid),
		.tile_stall(tile_stall),
		.tile(tile)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		tile_stall <= !quiet && ($urandom_range(99) < 17);
	end

	// Transfer monitor on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && !pixel_stall)
				tracker.add_pixel(pixel);
			if (tile_valid && !tile_stall)
				tracker.match_tile(tile);
		end
	end

	function automatic logic [CH_W-1:0] channel_value();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return CH_W'($urandom_range(255));
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		px.red = channel_value();
		px.green = channel_value();
		px.blue = channel_value();
		return px;
	endfunction

	// Rotating extreme and alternating-bit levels
	function automatic pixel_t level_pixel(int unsigned step);
		logic [CH_W-1:0] levels [4] = '{8'h00, 8'hFF, 8'hAA, 8'h55};
		pixel_t px;
		px.red = levels[step % 4];
		px.green = levels[(step + 1) % 4];
		px.blue = levels[(step + 2) % 4];
		return px;
	endfunction

	// Called at a clock edge; returns at the edge where the transfer happens
	task automatic push_pixel(input pixel_t px);
		while (!quiet && $urandom_range(99) < 17) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
	endtask

	task automatic hold_for_results();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (tracker.due_tiles.size() != 0)
			@(posedge clk);
	endtask

	// Pixels that finish no tile may still be in the pipe: wait out the latency too
	task automatic settle();
		hold_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= DIM_W'(value);
		tracker.set_register(idx, value);
		@(posedge clk);
	endtask

	task automatic run_phase(input int unsigned iw, ih, tc, tw, th, count, input bit patterned);
		settle();
		write_reg(CFG_IMAGE_WIDTH, iw);
		write_reg(CFG_IMAGE_HEIGHT, ih);
		write_reg(CFG_TILE_COUNT, tc);
		write_reg(CFG_TILE_WIDTH, tw);
		write_reg(CFG_TILE_HEIGHT, th);
		cfg_we <= 1'b0;
		for (int i = 0; i < count; i++) begin
			if (!patterned && $urandom_range(149) == 0)
				hold_for_results();
			if (patterned) begin
				push_pixel(level_pixel(pattern_step));
				pattern_step++;
			end else begin
				push_pixel(random_pixel());
			end
		end
	endtask

	initial begin
		int unsigned tc, tw, th, iw, ih, frame, count, random_done;
		int phase_no;
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = '0;
		pixel_valid = 1'b0;
		pixel = '0;
		tile_stall = 1'b0;
		quiet = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one 4096 x 4096 tile, nothing completes
		repeat (2) begin
			push_pixel(level_pixel(pattern_step));
			pattern_step++;
		end
		// small grid written mid-frame, then whole frames
		run_phase(4, 2, 2, 2, 1, 10, 1'b1);
		// zero registers act as one
		run_phase(0, 3, 0, 0, 0, 3, 1'b1);
		// realign, then a grid larger than the image
		run_phase(1, 1, 1, 1, 1, 1, 1'b1);
		run_phase(3, 2, 2, 2, 2, 6, 1'b1);
		// out-of-range values saturate
		run_phase(8191, 8191, 127, 8191, 8191, 2, 1'b1);

		// Full 64 x 64 grid: one column of 1x1 tiles, then widen for the bottom row
		run_phase(1, 1, 1, 1, 1, 1, 1'b0);
		run_phase(1, 64, 64, 1, 1, 63, 1'b0);
		run_phase(64, 64, 64, 1, 1, 64, 1'b0);
		// wide and tall single tiles, one with no idling
		quiet = 1'b1;
		run_phase(256, 1, 1, 256, 1, 256, 1'b0);
		quiet = 1'b0;
		run_phase(1, 128, 1, 1, 128, 128, 1'b0);

		// Random grids, mostly whole frames
		random_done = 0;
		phase_no = 0;
		while (random_done < RANDOM_PIXELS) begin
			tc = ($urandom_range(7) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
			tw = $urandom_range(4, 1);
			th = $urandom_range(3, 1);
			case ($urandom_range(9))
				0, 1: begin
					// uncovered margin right, and sometimes below
					iw = tc * tw + $urandom_range(3, 1);
					ih = tc * th + $urandom_range(2, 0);
				end
				2: begin
					// last tile column never completes, unless the grid is one pixel wide
					iw = (tc * tw > 1) ? tc * tw - 1 : 1;
					ih = tc * th;
				end
				default: begin
					iw = tc * tw;
					ih = tc * th;
				end
			endcase
			frame = iw * ih;
			count = (frame > 150) ? frame : frame * $urandom_range(3, 1);
			if ($urandom_range(6) == 0)
				count = $urandom_range(frame, 1);  // stop mid-frame
			// keep the total near the pixel budget
			if (count > RANDOM_PIXELS - random_done)
				count = RANDOM_PIXELS - random_done;
			quiet = (phase_no % 6 == 5);
			run_phase(iw, ih, tc, tw, th, count, 1'b0);
			random_done += count;
			phase_no++;
		end
		quiet = 1'b0;

		settle();
		if (tracker.errors == 0 && tracker.due_tiles.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
